// ===== hdl/slcd_pkg.sv =====
// Shared types, command codes and glyph tables for the segment LCD frame formatter.
// Depends on nothing; used by segment_lcd_frame_formatter_core.
package slcd_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [1:0]         dot_position;
      logic [7:0]         percent;
      logic [47:0]        text;
      logic [2:0]         text_length;
   } req_type;

   typedef struct packed {
      logic [63:0] frame;
      logic [6:0]  frame_bits;
      logic        last;
   } rsp_type;

   // Command codes
   localparam logic [2:0] CMD_INIT    = 3'd0;
   localparam logic [2:0] CMD_ON      = 3'd1;
   localparam logic [2:0] CMD_OFF     = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_BATTERY = 3'd4;
   localparam logic [2:0] CMD_TEXT    = 3'd5;
   localparam logic [2:0] CMD_INTEGER = 3'd6;
   localparam logic [2:0] CMD_SCALED  = 3'd7;

   localparam int unsigned DIGITS = 6;

   // Controller command bytes
   localparam logic [7:0] CTRL_DISPLAY_ON  = 8'h06;
   localparam logic [7:0] CTRL_DISPLAY_OFF = 8'h04;
   localparam logic [7:0] INIT_CMDS [0:5] = '{8'h52, 8'h30, 8'h00, 8'h0A, 8'h02, 8'h06};

   // Frame lengths and fixed fields
   localparam logic [6:0] FRAME_BITS_CMD = 7'd16;
   localparam logic [6:0] FRAME_BITS_BUF = 7'd64;
   localparam logic [3:0] CMD_PREFIX     = 4'b1000;
   localparam logic [2:0] WRITE_PREFIX   = 3'b101;

   localparam logic [6:0] GLYPH_MINUS = 7'h02;

   // Seven-segment glyphs for codes 0x20..0x7F
   localparam logic [7:0] GLYPH_TABLE [0:95] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
      8'h7D, 8'h60, 8'h3E, 8'h7A, 8'h63, 8'h5B, 8'h5F, 8'h70,
      8'h7F, 8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h77, 8'h4F, 8'h1D, 8'h6E, 8'h1F, 8'h17, 8'h5D,
      8'h47, 8'h05, 8'h68, 8'h27, 8'h0D, 8'h54, 8'h75, 8'h4E,
      8'h37, 8'h73, 8'h06, 8'h59, 8'h0F, 8'h6D, 8'h23, 8'h29,
      8'h67, 8'h6B, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08,
      8'h00, 8'h77, 8'h4F, 8'h1D, 8'h6E, 8'h1F, 8'h17, 8'h5D,
      8'h47, 8'h05, 8'h68, 8'h27, 8'h0D, 8'h54, 8'h75, 8'h4E,
      8'h37, 8'h73, 8'h06, 8'h59, 8'h0F, 8'h6D, 8'h23, 8'h29,
      8'h67, 8'h6B, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // Look up the glyph of an ASCII code; codes outside 0x20..0x7F are blank
   function automatic logic [6:0] glyph_of(input logic [7:0] code);
      logic [6:0] idx;
      idx = 7'(code - 8'h20);
      if (code[7] || (code < 8'h20)) begin
         return 7'h00;
      end
      return GLYPH_TABLE[idx][6:0];
   endfunction

endpackage

// ===== hdl/segment_lcd_frame_formatter_core.sv =====
// Segment LCD frame formatter: segment buffer, command sequencer and frame output register.
// Depends on slcd_pkg for payload types, command codes and glyph tables.
//
// Usage
//   Requests arrive on req_valid/req_ready/req_data, one command each. Frames leave on
//   rsp_valid/rsp_ready/rsp_data, left aligned in 64 bits, with last set on the final frame
//   that a request causes. A request is taken only while the sequencer is idle.
// Frames and sequencing
//   Display on/off, clear and battery: one frame, issued once the output register is free.
//   Init: six command frames, one per cycle unless the receiver stalls. Text: the
//   characters are placed in turn, then one frame. Integer: the decimal digits (up to
//   six) are peeled in turn through a shared divide-by-ten unit (reciprocal multiply and
//   remainder), then one frame; scaled adds a second frame. A request occupies the block
//   until its last frame is loaded; without stalls, the digit loop sets the longest case.
// Reset
//   Synchronous, active high: the segment buffer is cleared and no frame is pending.
// Receiver stalls
//   The output register holds its frame until taken; the sequencer waits and no frame is
//   lost or repeated. A new request may be taken while the last frame still waits.
module segment_lcd_frame_formatter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slcd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slcd_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMD,
      S_TEXT,
      S_DIGIT,
      S_BUF
   } state_type;

   state_type         state_ff;
   logic [2:0]        command_ff;
   logic [2:0]        count_ff;
   logic [2:0]        len_ff;
   logic [47:0]       text_ff;
   logic [19:0]       mag_ff;
   logic              neg_ff;
   logic [2:0]        pos_ff;
   logic [1:0]        dot_ff;
   logic              dot_pend_ff;
   logic [6:0]        glyph_ff [slcd_pkg::DIGITS];
   logic              seg_ff [slcd_pkg::DIGITS];
   slcd_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   logic              out_free;
   logic              rsp_load;
   logic [19:0]       mag_in;
   logic              neg_in;
   logic [2:0]        len_in;
   logic [43:0]       prod;
   logic [19:0]       quot_in;
   logic [19:0]       quot_x10;
   logic [19:0]       rem_full;
   logic [6:0]        digit_glyph;
   logic [7:0]        cmd_byte;
   logic              cmd_last;
   logic [63:0]       buf_frame;
   logic [2:0]        dot_idx;
   logic [2:0]        minus_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = out_free && ((state_ff == S_CMD) || (state_ff == S_BUF));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Clamp the number and take its magnitude
   always_comb begin
      neg_in = req_data.value[31];
      if (req_data.value > 32'sd999999) begin
         mag_in = 20'd999999;
      end else if (req_data.value < -32'sd99999) begin
         mag_in = 20'd99999;
      end else if (req_data.value[31]) begin
         mag_in = 20'(-req_data.value);
      end else begin
         mag_in = 20'(req_data.value);
      end
      len_in = (req_data.text_length > 3'd6) ? 3'd6 : req_data.text_length;
   end

   // Shared divide-by-ten unit: reciprocal multiply, then remainder by shift and add
   always_comb begin
      prod        = 44'(mag_ff) * 44'd838861;
      quot_in     = prod[42:23];
      quot_x10    = {quot_in[16:0], 3'b000} + {quot_in[18:0], 1'b0};
      rem_full    = mag_ff - quot_x10;
      digit_glyph = slcd_pkg::glyph_of(8'h30 + {4'b0000, rem_full[3:0]});
   end

   // Command frame byte selection
   always_comb begin
      if (command_ff == slcd_pkg::CMD_INIT) begin
         cmd_byte = slcd_pkg::INIT_CMDS[count_ff];
         cmd_last = (count_ff == 3'd5);
      end else if (command_ff == slcd_pkg::CMD_ON) begin
         cmd_byte = slcd_pkg::CTRL_DISPLAY_ON;
         cmd_last = 1'b1;
      end else begin
         cmd_byte = slcd_pkg::CTRL_DISPLAY_OFF;
         cmd_last = 1'b1;
      end
   end

   // Buffer write frame: prefix, zero address, bytes 5..0, zero tail
   always_comb begin
      buf_frame = '0;
      buf_frame[63:61] = slcd_pkg::WRITE_PREFIX;
      for (int i = 0; i < slcd_pkg::DIGITS; i++) begin
         buf_frame[7 + 8 * i +: 8] = {seg_ff[i], glyph_ff[i]};
      end
   end

   assign dot_idx   = 3'(3'd6 - {1'b0, dot_ff});
   assign minus_idx = 3'(pos_ff - 3'd1);

   // Sequencer, segment buffer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dot_pend_ff  <= 1'b0;
         for (int i = 0; i < slcd_pkg::DIGITS; i++) begin
            glyph_ff[i] <= 7'h00;
            seg_ff[i]   <= 1'b0;
         end
      end else begin
         // Drop the frame once taken, unless a new one is loaded
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  command_ff  <= req_data.command;
                  count_ff    <= 3'd0;
                  dot_ff      <= req_data.dot_position;
                  unique case (req_data.command) inside
                     slcd_pkg::CMD_INIT, slcd_pkg::CMD_ON, slcd_pkg::CMD_OFF: begin
                        state_ff <= S_CMD;
                     end
                     slcd_pkg::CMD_CLEAR: begin
                        for (int i = 0; i < slcd_pkg::DIGITS; i++) begin
                           glyph_ff[i] <= 7'h00;
                           seg_ff[i]   <= 1'b0;
                        end
                        state_ff <= S_BUF;
                     end
                     slcd_pkg::CMD_BATTERY: begin
                        seg_ff[0] <= (req_data.percent > 8'd75);
                        seg_ff[1] <= (req_data.percent > 8'd50);
                        seg_ff[2] <= (req_data.percent > 8'd25);
                        state_ff  <= S_BUF;
                     end
                     slcd_pkg::CMD_TEXT: begin
                        for (int i = 0; i < slcd_pkg::DIGITS; i++) begin
                           glyph_ff[i] <= 7'h00;
                        end
                        seg_ff[3] <= 1'b0;
                        seg_ff[4] <= 1'b0;
                        seg_ff[5] <= 1'b0;
                        text_ff   <= req_data.text;
                        len_ff    <= len_in;
                        state_ff  <= (len_in == 3'd0) ? S_BUF : S_TEXT;
                     end
                     slcd_pkg::CMD_INTEGER, slcd_pkg::CMD_SCALED: begin
                        for (int i = 0; i < slcd_pkg::DIGITS; i++) begin
                           glyph_ff[i] <= 7'h00;
                        end
                        seg_ff[3]   <= 1'b0;
                        seg_ff[4]   <= 1'b0;
                        seg_ff[5]   <= 1'b0;
                        mag_ff      <= mag_in;
                        neg_ff      <= neg_in;
                        pos_ff      <= 3'd5;
                        dot_pend_ff <= (req_data.command == slcd_pkg::CMD_SCALED);
                        state_ff    <= S_DIGIT;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_CMD: begin
               // Issue one controller command frame a cycle while the output register is free
               if (out_free) begin
                  rsp_ff.frame      <= {slcd_pkg::CMD_PREFIX, cmd_byte, 4'b0000, 48'h0};
                  rsp_ff.frame_bits <= slcd_pkg::FRAME_BITS_CMD;
                  rsp_ff.last       <= cmd_last;
                  rsp_valid_ff      <= 1'b1;
                  count_ff          <= 3'(count_ff + 3'd1);
                  if (cmd_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_TEXT: begin
               // Place one character a cycle, first character in byte 0
               glyph_ff[count_ff] <= slcd_pkg::glyph_of(text_ff[47:40]);
               text_ff            <= {text_ff[39:0], 8'h00};
               count_ff           <= 3'(count_ff + 3'd1);
               if (3'(count_ff + 3'd1) == len_ff) begin
                  state_ff <= S_BUF;
               end
            end
            S_DIGIT: begin
               // Peel one decimal digit a cycle, rightmost place first
               glyph_ff[pos_ff] <= digit_glyph;
               mag_ff           <= quot_in;
               pos_ff           <= minus_idx;
               if ((quot_in == 20'd0) || (pos_ff == 3'd0)) begin
                  if (neg_ff && (pos_ff != 3'd0)) begin
                     glyph_ff[minus_idx] <= slcd_pkg::GLYPH_MINUS;
                  end
                  state_ff <= S_BUF;
               end
            end
            S_BUF: begin
               // Issue the buffer frame; for scaled, set the dot and issue again
               if (out_free) begin
                  rsp_ff.frame      <= buf_frame;
                  rsp_ff.frame_bits <= slcd_pkg::FRAME_BITS_BUF;
                  rsp_ff.last       <= !dot_pend_ff;
                  rsp_valid_ff      <= 1'b1;
                  if (dot_pend_ff) begin
                     for (int i = 3; i < slcd_pkg::DIGITS; i++) begin
                        seg_ff[i] <= (dot_ff != 2'd0) && (dot_idx == 3'(i));
                     end
                     dot_pend_ff <= 1'b0;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // Every command keeps the sequencer busy in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // Command frames carry nothing below the 16 frame bits
   a_cmd_frame_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.frame_bits == slcd_pkg::FRAME_BITS_CMD))
      |-> (rsp_data.frame[47:0] == 48'h0))
      else $error("command frame has stray low bits");

   // Buffer frames always open with the write prefix
   a_buf_prefix: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.frame_bits == slcd_pkg::FRAME_BITS_BUF))
      |-> (rsp_data.frame[63:61] == slcd_pkg::WRITE_PREFIX))
      else $error("buffer frame without write prefix");

   // A frame that is not last means more frames of the same request follow
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> (state_ff != S_IDLE))
      else $error("sequencer idle while request still has frames");

   // The digit place never runs past the buffer
   a_digit_place: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIGIT) |-> (pos_ff <= 3'd5))
      else $error("digit place out of range");
`endif

endmodule
